FILE: design/isd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isd_pkg
// Shared types, format codes and the signature table for the image
// signature detector.
// ----------------------------------------------------------------------------
package isd_pkg;

  localparam int SIG_COUNT = 10;
  localparam int SIG_SPAN  = 12;
  localparam int POS_W     = 4;
  localparam int CODE_W    = 4;

  typedef logic [SIG_COUNT-1:0] sig_mask_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [CODE_W-1:0]    fmt_code_t;
  typedef logic [SIG_SPAN-1:0]  care_t;

  typedef struct packed {
    pos_t      pos;
    sig_mask_t match;
  } isd_state_t;

  localparam fmt_code_t FMT_UNKNOWN = 4'd0;
  localparam fmt_code_t FMT_JPEG    = 4'd1;
  localparam fmt_code_t FMT_PNG     = 4'd2;
  localparam fmt_code_t FMT_WEBP    = 4'd3;
  localparam fmt_code_t FMT_JP2     = 4'd4;
  localparam fmt_code_t FMT_J2K     = 4'd5;
  localparam fmt_code_t FMT_TIFF    = 4'd6;
  localparam fmt_code_t FMT_BMP     = 4'd7;
  localparam fmt_code_t FMT_GIF     = 4'd8;

  localparam pos_t POS_MAX = POS_W'(SIG_SPAN);

  localparam isd_state_t ISD_REARM = '{pos: '0, match: '1};

  // Candidates are listed in priority order, highest first.
  localparam logic [7:0] SIG_PAT [SIG_COUNT][SIG_SPAN] = '{
    '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h57, 8'h45, 8'h42, 8'h50},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h6A, 8'h50, 8'h20, 8'h20,
      8'h0D, 8'h0A, 8'h87, 8'h0A},
    '{8'hFF, 8'h4F, 8'hFF, 8'h51, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h49, 8'h49, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4D, 8'h4D, 8'h00, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h42, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam care_t SIG_CARE [SIG_COUNT] = '{
    12'h007, 12'h0FF, 12'hF0F, 12'hFF0, 12'h00F,
    12'h00F, 12'h00F, 12'h003, 12'h03F, 12'h03F
  };

  localparam pos_t SIG_LEN [SIG_COUNT] = '{
    4'd3, 4'd8, 4'd12, 4'd12, 4'd4, 4'd4, 4'd4, 4'd2, 4'd6, 4'd6
  };

  localparam fmt_code_t SIG_CODE [SIG_COUNT] = '{
    FMT_JPEG, FMT_PNG, FMT_WEBP, FMT_JP2, FMT_J2K,
    FMT_TIFF, FMT_TIFF, FMT_BMP, FMT_GIF, FMT_GIF
  };

endpackage

FILE: design/isd_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isd_match
// Compares one file byte against every candidate signature at the current
// position and advances the saturating byte position.
// ----------------------------------------------------------------------------
module isd_match (
  input  isd_pkg::isd_state_t state_i,
  input  logic [7:0]          data_byte,
  input  logic                byte_present,
  output isd_pkg::isd_state_t state_o
);
  import isd_pkg::*;

  always_comb begin
    state_o = state_i;
    if (byte_present && (state_i.pos < POS_MAX)) begin
      for (int i = 0; i < SIG_COUNT; i++) begin
        if (SIG_CARE[i][state_i.pos] && (SIG_PAT[i][state_i.pos] != data_byte)) begin
          state_o.match[i] = 1'b0;
        end
      end
      state_o.pos = state_i.pos + pos_t'(1);
    end
  end

endmodule

FILE: design/isd_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isd_classify
// Picks the highest-priority candidate that still matches and whose length
// fits within the bytes seen.
// ----------------------------------------------------------------------------
module isd_classify (
  input  isd_pkg::isd_state_t state_i,
  output isd_pkg::fmt_code_t  format_code
);
  import isd_pkg::*;

  always_comb begin
    format_code = FMT_UNKNOWN;
    for (int i = SIG_COUNT - 1; i >= 0; i--) begin
      if (state_i.match[i] && (state_i.pos >= SIG_LEN[i])) begin
        format_code = SIG_CODE[i];
      end
    end
  end

endmodule

FILE: design/image_signature_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_signature_detector
// Classifies an image container from the leading bytes of a file.
// ----------------------------------------------------------------------------
// The format code is registered and valid in the cycle after the last item is accepted.
// Throughput: one item per cycle while no result waits, set by the single match and classify stage.
// A result that waits holds off requests; one is taken in the cycle it leaves.
// Reset clears the byte position, sets all match bits and drops out_valid.
// ----------------------------------------------------------------------------
module image_signature_detector (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_byte_present,
  input  logic                in_is_last,
  output logic                out_valid,
  input  logic                out_ready,
  output isd_pkg::fmt_code_t  out_format_code
);
  import isd_pkg::*;

  isd_state_t state_r, state_nxt, state_taken;
  fmt_code_t  code_r, code_nxt, code_comb;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;

  assign in_ready        = !out_valid_r || out_ready;
  assign in_fire         = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_format_code = code_r;

  isd_match u_match (
    .state_i      (state_r),
    .data_byte    (in_data_byte),
    .byte_present (in_byte_present),
    .state_o      (state_taken)
  );

  isd_classify u_classify (
    .state_i     (state_taken),
    .format_code (code_comb)
  );

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (in_fire) begin
      if (in_is_last) begin
        state_nxt     = ISD_REARM;
        code_nxt      = code_comb;
        out_valid_nxt = 1'b1;
      end else begin
        state_nxt = state_taken;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ISD_REARM;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pos <= POS_MAX)
    else $error("byte position beyond signature span");

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_is_last |=> (state_r == ISD_REARM) && out_valid_r)
    else $error("detector did not rearm or present a result after end of file");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !in_ready)
    else $error("request accepted while a result is held");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_is_last && in_byte_present && (state_r.pos < POS_MAX)
    |=> state_r.pos == $past(state_r.pos) + pos_t'(1))
    else $error("byte position did not advance");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> code_r <= FMT_GIF)
    else $error("format code out of range");

endmodule
